/* src/div128_pkg.sv */
package div128_pkg;

  // Word width of every operand and result.
  localparam int unsigned WordW = 64;
  // Width of the step counter: one step per quotient bit.
  localparam int unsigned CntW  = $clog2(WordW);

  typedef logic [WordW-1:0] word_t;

  // Quotient and remainder reported when the quotient does not fit.
  localparam word_t AllOnes = {WordW{1'b1}};

  // State carried from one restoring step to the next.
  typedef struct packed {
    word_t rem;    // partial remainder
    word_t shift;  // unconsumed dividend bits, quotient bits shifted in below
  } div128_step_t;

endpackage

/* src/div128_if.sv */
// Input channel: one division request per transaction.
interface div128_in_if;
  import div128_pkg::*;

  logic  valid;
  logic  ready;
  word_t dividend_high;
  word_t dividend_low;
  word_t divisor;

  modport source (output valid, output dividend_high, output dividend_low,
                  output divisor, input ready);
  modport sink   (input valid, input dividend_high, input dividend_low,
                  input divisor, output ready);
endinterface

// Output channel: one quotient, remainder and overflow flag per transaction.
interface div128_out_if;
  import div128_pkg::*;

  logic  valid;
  logic  ready;
  word_t quotient;
  word_t remainder;
  logic  overflow;

  modport source (output valid, output quotient, output remainder,
                  output overflow, input ready);
  modport sink   (input valid, input quotient, input remainder,
                  input overflow, output ready);
endinterface

/* src/div128_step.sv */
// One radix-2 restoring division step: shift one dividend bit into the
// partial remainder, subtract the divisor when it fits, and record the
// quotient bit in the freed low end of the shift register.
module div128_step (
  input  div128_pkg::div128_step_t cur_i,
  input  div128_pkg::word_t        divisor_i,
  output div128_pkg::div128_step_t nxt_o
);
  import div128_pkg::*;

  logic  carry;
  word_t shifted;
  logic  take;

  // The true partial remainder is the 65-bit value {carry, shifted}, which
  // stays below twice the divisor, so one compare and subtract suffices.
  always_comb begin
    carry     = cur_i.rem[WordW-1];
    shifted   = {cur_i.rem[WordW-2:0], cur_i.shift[WordW-1]};
    take      = carry | (shifted >= divisor_i);
    nxt_o.rem = take ? (shifted - divisor_i) : shifted;
    nxt_o.shift = {cur_i.shift[WordW-2:0], take};
  end

endmodule

/* src/div128_top_unused_placeholder.sv */
// Result register stage: holds a finished result until the output channel
// takes it, so the sequencer can start the next division meanwhile.
module div128_outreg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  div128_pkg::word_t          quotient_i,
  input  div128_pkg::word_t          remainder_i,
  input  logic                       overflow_i,
  output logic                       full_o,
  div128_out_if.source               out_o
);
  import div128_pkg::*;

  logic  valid_q;
  word_t quo_q;
  word_t rem_q;
  logic  ovf_q;

  // A slot is free when empty or when its transaction completes this cycle.
  assign full_o = valid_q & ~out_o.ready;

  // Valid flag under reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quo_q <= quotient_i;
      rem_q <= remainder_i;
      ovf_q <= overflow_i;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.quotient  = quo_q;
  assign out_o.remainder = rem_q;
  assign out_o.overflow  = ovf_q;

endmodule

/* src/divide_128_by_64_unsigned_unit.sv */
// Channel | Dir | Fields
// in_i    | in  | dividend_high[63:0], dividend_low[63:0], divisor[63:0]
// out_o   | out | quotient[63:0], remainder[63:0], overflow
//
// A division runs in order: the accept edge captures the operands, 64 restoring
// steps of the shared compare-subtract unit follow, and then the result register
// is loaded, which raises out_o.valid. Overflow (high half >= divisor, zero
// divisor too) skips the steps and goes straight to the finish state. in_i.ready
// is high only while idle, and a result waits in the output register while the
// next division runs; a finished division holds until that register is free.
// Reset clears the sequencer and output valid.
module divide_128_by_64_unsigned_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  div128_in_if.sink    in_i,
  div128_out_if.source out_o
);
  import div128_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFinish
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  div128_step_t    work_q, work_d;
  div128_step_t    step_nxt;
  word_t           div_q, div_d;
  logic            ovf_q, ovf_d;
  logic            out_full;
  logic            load;
  logic            accept;

  // Shared restoring step unit.
  div128_step u_step (
    .cur_i     (work_q),
    .divisor_i (div_q),
    .nxt_o     (step_nxt)
  );

  // Output register stage.
  div128_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .quotient_i  (ovf_q ? AllOnes : work_q.shift),
    .remainder_i (ovf_q ? AllOnes : work_q.rem),
    .overflow_i  (ovf_q),
    .full_o      (out_full),
    .out_o       (out_o)
  );

  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid & in_i.ready;
  assign load       = (state_q == StFinish) & ~out_full;

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    work_d  = work_q;
    div_d   = div_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          work_d.rem   = in_i.dividend_high;
          work_d.shift = in_i.dividend_low;
          div_d        = in_i.divisor;
          ovf_d        = (in_i.dividend_high >= in_i.divisor);
          cnt_d        = '1;
          state_d      = (in_i.dividend_high >= in_i.divisor) ? StFinish : StRun;
        end
      end
      StRun: begin
        work_d = step_nxt;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_full) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state under reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working registers need no reset.
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    div_q  <= div_d;
    ovf_q  <= ovf_d;
  end

endmodule
